// ===== hdl/b2nv_pkg.sv =====
// Shared constants, types and helper function of the BGRA to NV12 converter.
package b2nv_pkg;

  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned PairDepth = (MaxWidth + 1) / 2;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned RowW      = $clog2(MaxHeight);
  localparam int unsigned SlotW     = $clog2(PairDepth);
  localparam int unsigned DimW      = 13;
  localparam int unsigned SumW      = 9;

  localparam logic [7:0] YCoefR   = 8'd77;
  localparam logic [7:0] YCoefG   = 8'd150;
  localparam logic [7:0] YCoefB   = 8'd29;
  localparam logic [7:0] YRound   = 8'd128;
  localparam logic [7:0] UCoefR   = 8'd43;
  localparam logic [7:0] UCoefG   = 8'd85;
  localparam logic [7:0] VCoefG   = 8'd107;
  localparam logic [7:0] VCoefB   = 8'd21;
  localparam logic [16:0] COffset = 17'd32768;

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic             odd_col;
    logic             last_col;
    logic             odd_row;
    logic             last_row;
    logic [SlotW-1:0] slot;
  } pix_ctrl_t;

  // Saturates a dimension to 1..max and returns the index of its last element.
  function automatic logic [ColW-1:0] dim_last(input logic [DimW-1:0] v,
                                               input logic [DimW-1:0] max_dim);
    logic [DimW-1:0] eff;
    begin
      if (v == '0) begin
        eff = DimW'(1);
      end else if (v > max_dim) begin
        eff = max_dim;
      end else begin
        eff = v;
      end
      dim_last = ColW'(eff - DimW'(1));
    end
  endfunction

endpackage

// ===== hdl/bgra_to_nv12_converter_top.sv =====
// Converts a BGRA pixel stream to luma and 2x2-averaged NV12 chroma samples.
// A pixel's result is registered in the input, chroma and output stages.
// Throughput: one pixel per clock unless the output stalls; the line buffer is read
// one stage before its write; a forwarding register covers back-to-back entry reuse.
// Reset clears the counters, the pair sums and the pipeline, and sets the frame
// size to 1920 by 1080; the line buffer is not cleared and needs no clearing pass.
module bgra_to_nv12_converter_top
  import b2nv_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [0:0]      cfg_index_i,
  input  logic [DimW-1:0] cfg_data_i,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [23:0]     s_axis_tdata,   // blue, green, red
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [23:0]     m_axis_tdata,   // luma, cb_avg, cr_avg
  output logic            m_axis_tuser,   // chroma_valid
  output logic            m_axis_tlast    // frame_end
);

  logic [ColW-1:0] width_last_q, height_last_q;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;

  logic            v1_q, v2_q, v3_q;
  logic            en1, en2, en3, accept;
  logic [23:0]     pix1_q;
  pix_ctrl_t       ctrl_in, ctrl1_q, ctrl2_q;

  logic [7:0]      luma1, cb1, cr1;
  logic [16:0]     ysum, usum, vsum;
  logic [7:0]      luma2_q, cb2_q, cr2_q;

  logic [SumW-1:0] pair_cb_q, pair_cr_q, pair_cb_d, pair_cr_d;
  logic [2*SumW-1:0] mem [PairDepth];
  logic [2*SumW-1:0] rdata_q, fwd_q, upper;
  logic            fwd_hit_q;
  logic            rd_en, wr_en, closes, chroma_ok;
  logic [SumW:0]   blk_cb, blk_cr;
  logic [7:0]      cb_o, cr_o;

  logic [7:0]      luma3_q, cb3_q, cr3_q;
  logic            chroma3_q, end3_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_last_q  <= ColW'(1919);
      height_last_q <= RowW'(1079);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  width_last_q  <= dim_last(cfg_data_i, DimW'(MaxWidth));
        CFG_FRAME_HEIGHT: height_last_q <= dim_last(cfg_data_i, DimW'(MaxHeight));
        default: ;
      endcase
    end
  end

  assign en3    = !v3_q || m_axis_tready;
  assign en2    = !v2_q || en3;
  assign en1    = !v1_q || en2;
  assign s_axis_tready = en1;
  assign accept = s_axis_tvalid && en1;

  always_comb begin
    ctrl_in.odd_col  = col_q[0];
    ctrl_in.last_col = col_q >= width_last_q;
    ctrl_in.odd_row  = row_q[0];
    ctrl_in.last_row = row_q >= height_last_q;
    ctrl_in.slot     = col_q[ColW-1:1];
    col_d = col_q;
    row_d = row_q;
    if (ctrl_in.last_col) begin
      col_d = '0;
      row_d = ctrl_in.last_row ? '0 : row_q + RowW'(1);
    end else begin
      col_d = col_q + ColW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix1_q  <= s_axis_tdata;
      ctrl1_q <= ctrl_in;
    end
  end

  always_comb begin
    ysum = 17'(YCoefR) * 17'(pix1_q[23:16]) + 17'(YCoefG) * 17'(pix1_q[15:8])
         + 17'(YCoefB) * 17'(pix1_q[7:0]) + 17'(YRound);
    usum = 17'({pix1_q[7:0], 7'd0}) + COffset
         - 17'(UCoefR) * 17'(pix1_q[23:16]) - 17'(UCoefG) * 17'(pix1_q[15:8]);
    vsum = 17'({pix1_q[23:16], 7'd0}) + COffset
         - 17'(VCoefG) * 17'(pix1_q[15:8]) - 17'(VCoefB) * 17'(pix1_q[7:0]);
    luma1 = ysum[15:8];
    cb1   = usum[15:8];
    cr1   = vsum[15:8];
  end

  assign rd_en = v1_q && en2;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      luma2_q <= luma1;
      cb2_q   <= cb1;
      cr2_q   <= cr1;
      ctrl2_q <= ctrl1_q;
    end
  end

  always_comb begin
    closes    = ctrl2_q.odd_col || ctrl2_q.last_col;
    chroma_ok = closes && (ctrl2_q.odd_row || ctrl2_q.last_row);
    wr_en     = v2_q && en3 && closes && !ctrl2_q.odd_row;
    pair_cb_d = ctrl2_q.odd_col ? pair_cb_q + SumW'(cb2_q) : SumW'(cb2_q);
    pair_cr_d = ctrl2_q.odd_col ? pair_cr_q + SumW'(cr2_q) : SumW'(cr2_q);
    upper     = fwd_hit_q ? fwd_q : rdata_q;
    blk_cb    = (SumW+1)'(upper[SumW-1:0]) + (SumW+1)'(pair_cb_d);
    blk_cr    = (SumW+1)'(upper[2*SumW-1:SumW]) + (SumW+1)'(pair_cr_d);
    cb_o = '0;
    cr_o = '0;
    if (chroma_ok) begin
      if (ctrl2_q.odd_row) begin
        cb_o = ctrl2_q.odd_col ? blk_cb[9:2] : blk_cb[8:1];
        cr_o = ctrl2_q.odd_col ? blk_cr[9:2] : blk_cr[8:1];
      end else begin
        cb_o = ctrl2_q.odd_col ? pair_cb_d[8:1] : pair_cb_d[7:0];
        cr_o = ctrl2_q.odd_col ? pair_cr_d[8:1] : pair_cr_d[7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[ctrl2_q.slot] <= {pair_cr_d, pair_cb_d};
    end
    if (rd_en) begin
      rdata_q <= mem[ctrl1_q.slot];
      fwd_q   <= {pair_cr_d, pair_cb_d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
      pair_cb_q <= '0;
      pair_cr_q <= '0;
    end else begin
      if (en2) begin
        fwd_hit_q <= v1_q && wr_en && (ctrl1_q.slot == ctrl2_q.slot);
      end
      if (v2_q && en3) begin
        pair_cb_q <= pair_cb_d;
        pair_cr_q <= pair_cr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && en3) begin
      luma3_q   <= luma2_q;
      cb3_q     <= cb_o;
      cr3_q     <= cr_o;
      chroma3_q <= chroma_ok;
      end3_q    <= ctrl2_q.last_col && ctrl2_q.last_row;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {cr3_q, cb3_q, luma3_q};
  assign m_axis_tuser  = chroma3_q;
  assign m_axis_tlast  = end3_q;

  a_fwd_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit_q |-> v2_q)
    else $error("Forwarded line buffer entry without an item in the chroma stage.");

  a_frame_end_closes_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("Last pixel of a frame did not close a chroma block.");

  a_chroma_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[23:8] == 16'd0)
    else $error("Chroma samples are non-zero on a pixel that closes no block.");

  a_empty_stage_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> s_axis_tready)
    else $error("Input stalled although the first stage is empty.");

endmodule
